// ===== sv/aabb_pkg.sv =====
// Shared types and constants for the AABB overlap table.
// No dependencies; every other file in the block imports this package.
package aabb_pkg;

  localparam int TABLE_DEPTH = 8;
  localparam int COORD_W     = 32;
  localparam int ID_W        = 3;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Operation codes carried by func; code 7 is unused and behaves as size.
  typedef enum logic [2:0] {
    F_CLEAR  = 3'd0,
    F_ADD    = 3'd1,
    F_UPDATE = 3'd2,
    F_REMOVE = 3'd3,
    F_QPAIR  = 3'd4,
    F_QBOX   = 3'd5,
    F_SIZE   = 3'd6
  } aabb_func_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_FINISH
  } aabb_state_e;

  // One box, all bounds signed fixed point.
  typedef struct packed {
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_z;
  } aabb_box_t;

endpackage

// ===== sv/aabb_box_ram.sv =====
// Box storage: one write port and two registered read ports.
// Depends on aabb_pkg for the box type and table depth.
module aabb_box_ram import aabb_pkg::*; (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [ID_W-1:0]     waddr_i,
  input  aabb_box_t           wdata_i,
  input  logic [ID_W-1:0]     raddr_a_i,
  input  logic [ID_W-1:0]     raddr_b_i,
  output aabb_box_t           rdata_a_o,
  output aabb_box_t           rdata_b_o
);

  aabb_box_t mem [TABLE_DEPTH];
  aabb_box_t rdata_a_q;
  aabb_box_t rdata_b_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== sv/aabb_ovl_unit.sv =====
// Shared overlap comparator: tests two boxes on all three axes at once.
// Depends on aabb_pkg for the box type.
module aabb_ovl_unit import aabb_pkg::*; (
  input  aabb_box_t box_a_i,
  input  aabb_box_t box_b_i,
  output logic      hit_o
);

  logic ovl_x;
  logic ovl_y;
  logic ovl_z;

  // Touching boxes count as overlapping, so the compares are inclusive.
  assign ovl_x = (box_a_i.min_x <= box_b_i.max_x) && (box_b_i.min_x <= box_a_i.max_x);
  assign ovl_y = (box_a_i.min_y <= box_b_i.max_y) && (box_b_i.min_y <= box_a_i.max_y);
  assign ovl_z = (box_a_i.min_z <= box_b_i.max_z) && (box_b_i.min_z <= box_a_i.max_z);

  assign hit_o = ovl_x && ovl_y && ovl_z;

endmodule

// ===== sv/aabb_table_overlap_query.sv =====
// AABB table with overlap queries. Clear, add, update, remove and size each
// answer with one result word, strobed from the finish step; no new start is
// taken while busy. A pair query walks all slot pairs through one comparator,
// one pair a cycle; a box query walks every slot against the latched query box.
// Each hit word waits for the next hit or the end of the scan; results cannot stall.
// Reset (rst_ni low, asynchronous) clears all valid bits and the sequencer.
module aabb_table_overlap_query import aabb_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                func_i,
  input  logic [ID_W-1:0]           obj_id_i,
  input  logic signed [COORD_W-1:0] min_x_i,
  input  logic signed [COORD_W-1:0] min_y_i,
  input  logic signed [COORD_W-1:0] min_z_i,
  input  logic signed [COORD_W-1:0] max_x_i,
  input  logic signed [COORD_W-1:0] max_y_i,
  input  logic signed [COORD_W-1:0] max_z_i,
  output logic                      result_valid_o,
  output logic                      found_o,
  output logic [ID_W-1:0]           first_id_o,
  output logic [ID_W-1:0]           second_id_o,
  output logic [CNT_W-1:0]          entry_count_o,
  output logic                      last_o
);

  localparam logic [ID_W-1:0] LAST_ID     = ID_W'(TABLE_DEPTH - 1);
  localparam logic [ID_W-1:0] PAIR_LAST_I = ID_W'(TABLE_DEPTH - 2);

  aabb_state_e state_q, state_d;
  aabb_func_e  func;

  logic [TABLE_DEPTH-1:0] valid_q;
  logic [ID_W-1:0]        i_q, i_d, j_q, j_d;
  logic                   pair_q, pair_d;
  logic                   accept;
  logic                   issue;
  logic                   scan_last;
  logic                   id_ok;
  logic                   ram_we;
  aabb_box_t              in_box;
  aabb_box_t              qbox_q;
  aabb_box_t              rd_a;
  aabb_box_t              rd_b;
  aabb_box_t              cmp_b;
  logic                   ovl_hit;
  logic                   hit;
  logic [CNT_W-1:0]       cnt;

  // Compare stage, aligned with the registered RAM read data.
  logic                   rd_vld_q;
  logic                   rd_ok_q;
  logic [ID_W-1:0]        rd_i_q;
  logic [ID_W-1:0]        rd_j_q;

  // Held-back hit, released once the next hit or the end of scan is known.
  logic                   pend_q;
  logic [ID_W-1:0]        pend_i_q;
  logic [ID_W-1:0]        pend_j_q;

  // Output word registers.
  logic                   res_vld_q;
  logic                   found_q;
  logic [ID_W-1:0]        first_q;
  logic [ID_W-1:0]        second_q;
  logic [CNT_W-1:0]       count_q;
  logic                   last_q;

  assign func   = aabb_func_e'(func_i);
  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);
  assign id_ok  = {1'b0, obj_id_i} < (ID_W + 1)'(TABLE_DEPTH);

  assign in_box = '{min_x: min_x_i, min_y: min_y_i, min_z: min_z_i,
                    max_x: max_x_i, max_y: max_y_i, max_z: max_z_i};

  // Add always writes; update writes only over a present entry.
  assign ram_we = accept && id_ok &&
                  ((func == F_ADD) || ((func == F_UPDATE) && valid_q[obj_id_i]));

  // Number of valid entries.
  always_comb begin
    cnt = '0;
    for (int s = 0; s < TABLE_DEPTH; s++) begin
      cnt = cnt + CNT_W'(valid_q[s]);
    end
  end

  aabb_box_ram u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (obj_id_i),
    .wdata_i   (in_box),
    .raddr_a_i (i_q),
    .raddr_b_i (j_q),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // A box query compares each entry against the latched query box.
  assign cmp_b = pair_q ? rd_b : qbox_q;

  aabb_ovl_unit u_ovl (
    .box_a_i (rd_a),
    .box_b_i (cmp_b),
    .hit_o   (ovl_hit)
  );

  assign hit = rd_vld_q && rd_ok_q && ovl_hit;

  assign scan_last = pair_q ? ((i_q == PAIR_LAST_I) && (j_q == LAST_ID)) : (i_q == LAST_ID);

  // Sequencer: next state and scan counters.
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    pair_d  = pair_q;
    issue   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (func)
            F_QPAIR: begin
              state_d = S_SCAN;
              pair_d  = 1'b1;
              i_d     = '0;
              j_d     = ID_W'(1);
            end
            F_QBOX: begin
              state_d = S_SCAN;
              pair_d  = 1'b0;
              i_d     = '0;
              j_d     = '0;
            end
            default: begin
              state_d = S_FINISH;
            end
          endcase
        end
      end
      S_SCAN: begin
        issue = 1'b1;
        if (scan_last) begin
          state_d = S_WAIT;
        end else if (!pair_q) begin
          i_d = i_q + ID_W'(1);
        end else if (j_q == LAST_ID) begin
          i_d = i_q + ID_W'(1);
          j_d = i_q + ID_W'(2);
        end else begin
          j_d = j_q + ID_W'(1);
        end
      end
      S_WAIT: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      pair_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      pair_q  <= pair_d;
    end
  end

  // Valid bits follow clear, add and remove.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (accept) begin
      case (func)
        F_CLEAR: valid_q <= '0;
        F_ADD: begin
          if (id_ok) begin
            valid_q[obj_id_i] <= 1'b1;
          end
        end
        F_REMOVE: begin
          if (id_ok) begin
            valid_q[obj_id_i] <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Query box is latched when the word is accepted.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      qbox_q <= in_box;
    end
  end

  // Compare stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ok_q <= valid_q[i_q] && (!pair_q || valid_q[j_q]);
    rd_i_q  <= i_q;
    rd_j_q  <= pair_q ? j_q : '0;
  end

  // Held-back hit so that the final word can carry last.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (state_q == S_FINISH) begin
      pend_q <= 1'b0;
    end else if (hit) begin
      pend_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit) begin
      pend_i_q <= rd_i_q;
      pend_j_q <= rd_j_q;
    end
  end

  // Output word: a held hit is released by a newer hit or by the finish step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= (hit && pend_q) || (state_q == S_FINISH);
    end
  end

  always_ff @(posedge clk_i) begin
    count_q <= cnt;
    if (state_q == S_FINISH) begin
      found_q  <= pend_q;
      first_q  <= pend_q ? pend_i_q : '0;
      second_q <= pend_q ? pend_j_q : '0;
      last_q   <= 1'b1;
    end else begin
      found_q  <= 1'b1;
      first_q  <= pend_i_q;
      second_q <= pend_j_q;
      last_q   <= 1'b0;
    end
  end

  assign result_valid_o = res_vld_q;
  assign found_o        = found_q;
  assign first_id_o     = first_q;
  assign second_id_o    = second_q;
  assign entry_count_o  = count_q;
  assign last_o         = last_q;

  // A word without a hit is always the final word of its operation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !found_o) |-> last_o)
    else $error("Empty result word not marked last.");

  // Empty words carry zero ids.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !found_o) |-> (first_id_o == '0) && (second_id_o == '0))
    else $error("Empty result word carries nonzero ids.");

  // Pair hits are ordered lower id first.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && found_o && (second_id_o != '0)) |-> (first_id_o < second_id_o))
    else $error("Pair hit ids out of order.");

  // No hit may be held while the block is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_q)
    else $error("Held hit left over after operation end.");

  // The finish step always produces exactly one final word next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH) |=> (result_valid_o && last_o))
    else $error("Finish step did not produce the final word.");

endmodule

// ===== bench/tb_aabb_table_overlap_query.sv =====
`timescale 1ns / 1ps
// Self-checking bench for aabb_table_overlap_query: a shadow table predicts every
// result word, which is checked against the strobed outputs. Depends on aabb_pkg.
module tb_aabb_table_overlap_query;
  import aabb_pkg::*;

  localparam logic [2:0] FUNC_SPARE   = 3'd7;
  localparam int         LIMIT_CYCLES = 300000;
  localparam int         SETTLE_CYCLES = 40;
  localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] C_ONE = 32'sh0001_0000;

  // One command word plus the pacing that goes with it.
  typedef struct {
    logic [2:0]      func;
    logic [ID_W-1:0] obj_id;
    aabb_box_t       box;
    int unsigned     gap_pct;
    bit              drain_first;
  } table_cmd_t;

  typedef struct packed {
    logic             found;
    logic [ID_W-1:0]  first_id;
    logic [ID_W-1:0]  second_id;
    logic [CNT_W-1:0] count;
    logic             last;
  } table_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] func_i = '0;
  logic [ID_W-1:0] obj_id_i = '0;
  logic signed [COORD_W-1:0] min_x_i = '0, min_y_i = '0, min_z_i = '0;
  logic signed [COORD_W-1:0] max_x_i = '0, max_y_i = '0, max_z_i = '0;
  logic result_valid_o, found_o, last_o;
  logic [ID_W-1:0] first_id_o, second_id_o;
  logic [CNT_W-1:0] entry_count_o;

  aabb_table_overlap_query u_top (
    .clk_i, .rst_ni, .start, .busy, .func_i, .obj_id_i,
    .min_x_i, .min_y_i, .min_z_i, .max_x_i, .max_y_i, .max_z_i,
    .result_valid_o, .found_o, .first_id_o, .second_id_o, .entry_count_o, .last_o
  );

  // Shadow copy of the table and the bench bookkeeping.
  logic         slot_live [TABLE_DEPTH];
  aabb_box_t    slot_box  [TABLE_DEPTH];
  table_cmd_t   cmd_backlog[$];
  table_reply_t replies_due[$];
  table_cmd_t   cur_cmd;
  bit           word_taken = 1'b0;
  int           mismatch_count = 0;
  int           replies_checked = 0;
  int           cmds_taken = 0;
  int           pair_scans = 0;
  int           box_scans = 0;
  int           widest_burst = 0;
  int           cycle_count = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Touching bounds count as overlap, compared as signed numbers.
  function automatic bit boxes_meet(input aabb_box_t a, input aabb_box_t b);
    return ($signed(a.min_x) <= $signed(b.max_x)) && ($signed(b.min_x) <= $signed(a.max_x)) &&
           ($signed(a.min_y) <= $signed(b.max_y)) && ($signed(b.min_y) <= $signed(a.max_y)) &&
           ($signed(a.min_z) <= $signed(b.max_z)) && ($signed(b.min_z) <= $signed(a.max_z));
  endfunction

  function automatic void note_reply(input logic found, input int a, input int b,
                                     input logic [CNT_W-1:0] cnt);
    table_reply_t rep;
    rep.found     = found;
    rep.first_id  = ID_W'(a);
    rep.second_id = ID_W'(b);
    rep.count     = cnt;
    rep.last      = 1'b0;
    replies_due = {replies_due, rep};
  endfunction

  // Applies one command to the shadow table and queues the words it produces.
  // Returns the number of hits found by a query.
  function automatic int apply_table_op(input table_cmd_t cmd);
    logic [CNT_W-1:0] live_count;
    int hits;
    int id;
    hits = 0;
    live_count = '0;
    id = int'(cmd.obj_id);
    case (cmd.func)
      F_CLEAR: begin
        for (int s = 0; s < TABLE_DEPTH; s++) slot_live[s] = 1'b0;
      end
      F_ADD: begin
        if (id < TABLE_DEPTH) begin
          slot_box[id]  = cmd.box;
          slot_live[id] = 1'b1;
        end
      end
      F_UPDATE: begin
        if (id < TABLE_DEPTH && slot_live[id]) slot_box[id] = cmd.box;
      end
      F_REMOVE: begin
        if (id < TABLE_DEPTH) slot_live[id] = 1'b0;
      end
      default: ;
    endcase
    for (int s = 0; s < TABLE_DEPTH; s++) live_count += CNT_W'(slot_live[s]);

    if (cmd.func == F_QPAIR) begin
      for (int i = 0; i < TABLE_DEPTH; i++)
        for (int j = i + 1; j < TABLE_DEPTH; j++)
          if (slot_live[i] && slot_live[j] && boxes_meet(slot_box[i], slot_box[j])) begin
            note_reply(1'b1, i, j, live_count);
            hits++;
          end
    end else if (cmd.func == F_QBOX) begin
      for (int i = 0; i < TABLE_DEPTH; i++)
        if (slot_live[i] && boxes_meet(slot_box[i], cmd.box)) begin
          note_reply(1'b1, i, 0, live_count);
          hits++;
        end
    end

    // A command without hits still answers with a single count word.
    if (hits == 0) note_reply(1'b0, 0, 0, live_count);
    replies_due[replies_due.size()-1].last = 1'b1;
    return hits;
  endfunction

  function automatic aabb_box_t span_box(input logic signed [COORD_W-1:0] lo,
                                         input logic signed [COORD_W-1:0] hi);
    aabb_box_t b;
    b.min_x = lo; b.min_y = lo; b.min_z = lo;
    b.max_x = hi; b.max_y = hi; b.max_z = hi;
    return b;
  endfunction

  // Half-unit grid around the origin, so that equal and touching bounds are common.
  function automatic logic signed [COORD_W-1:0] near_coord();
    int k;
    k = $urandom_range(0, 16);
    return COORD_W'((k - 8) * 32'sh8000);
  endfunction

  function automatic logic signed [COORD_W-1:0] extreme_coord();
    case ($urandom_range(0, 3))
      0: return C_MIN;
      1: return C_MAX;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // Mostly small well-formed boxes; some inverted, some raw, some at the range ends.
  function automatic aabb_box_t rand_box();
    logic signed [COORD_W-1:0] lo [3];
    logic signed [COORD_W-1:0] hi [3];
    logic signed [COORD_W-1:0] ext;
    aabb_box_t b;
    int mode;
    mode = $urandom_range(0, 99);
    for (int a = 0; a < 3; a++) begin
      ext = COORD_W'($urandom_range(0, 6) * 32'sh8000);
      if (mode < 70) begin
        lo[a] = near_coord();
        hi[a] = lo[a] + ext;
      end else if (mode < 80) begin
        hi[a] = near_coord();
        lo[a] = hi[a] + ext + 32'sh8000;
      end else if (mode < 90) begin
        lo[a] = $urandom;
        hi[a] = $urandom;
      end else begin
        lo[a] = extreme_coord();
        hi[a] = extreme_coord();
      end
    end
    b.min_x = lo[0]; b.min_y = lo[1]; b.min_z = lo[2];
    b.max_x = hi[0]; b.max_y = hi[1]; b.max_z = hi[2];
    return b;
  endfunction

  function automatic void queue_cmd(input logic [2:0] f, input int id, input aabb_box_t b,
                                    input int unsigned gap, input bit drain);
    table_cmd_t c;
    c.func        = f;
    c.obj_id      = ID_W'(id);
    c.box         = b;
    c.gap_pct     = gap;
    c.drain_first = drain;
    cmd_backlog = {cmd_backlog, c};
  endfunction

  // Driver: holds a word until it is taken, then launches the next one after a random gap.
  always @(negedge clk_i) begin
    if (rst_ni && (!start || word_taken)) begin
      word_taken = 1'b0;
      if (cmd_backlog.size() > 0 &&
          (!cmd_backlog[0].drain_first || replies_due.size() == 0) &&
          $urandom_range(0, 99) >= cmd_backlog[0].gap_pct) begin
        cur_cmd = cmd_backlog.pop_front();
        func_i   <= cur_cmd.func;
        obj_id_i <= cur_cmd.obj_id;
        min_x_i  <= cur_cmd.box.min_x;
        min_y_i  <= cur_cmd.box.min_y;
        min_z_i  <= cur_cmd.box.min_z;
        max_x_i  <= cur_cmd.box.max_x;
        max_y_i  <= cur_cmd.box.max_y;
        max_z_i  <= cur_cmd.box.max_z;
        start    <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks each strobed result word, then records a newly taken command.
  always @(posedge clk_i) begin
    table_reply_t want;
    int hits;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (replies_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"ERROR: unexpected result word found=%0b first=%0d second=%0d ",
                      "count=%0d last=%0b"},
                     found_o, first_id_o, second_id_o, entry_count_o, last_o);
        end else begin
          want = replies_due.pop_front();
          replies_checked++;
          if (found_o !== want.found || first_id_o !== want.first_id ||
              second_id_o !== want.second_id || entry_count_o !== want.count ||
              last_o !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"ERROR: result word %0d expected found=%0b first=%0d second=%0d ",
                        "count=%0d last=%0b, got found=%0b first=%0d second=%0d count=%0d last=%0b"},
                       replies_checked, want.found, want.first_id, want.second_id, want.count,
                       want.last, found_o, first_id_o, second_id_o, entry_count_o, last_o);
          end
        end
      end
      if (start && !busy) begin
        word_taken = 1'b1;
        cmds_taken++;
        hits = apply_table_op(cur_cmd);
        if (cur_cmd.func == F_QPAIR) begin
          pair_scans++;
          if (hits > widest_burst) widest_burst = hits;
        end else if (cur_cmd.func == F_QBOX) begin
          box_scans++;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int r;
    int unsigned gap;
    logic [2:0] f;
    aabb_box_t full_box;
    full_box = span_box(C_MIN, C_MAX);
    for (int s = 0; s < TABLE_DEPTH; s++) slot_live[s] = 1'b0;

    // Directed: empty table, range ends, touching corners, absent ids,
    // inverted boxes, the spare code and a full table.
    queue_cmd(F_CLEAR, 0, full_box, 0, 1'b0);
    queue_cmd(F_SIZE, 7, span_box('1, '1), 0, 1'b0);
    queue_cmd(F_QPAIR, 0, full_box, 0, 1'b0);
    queue_cmd(F_QBOX, 0, full_box, 0, 1'b0);
    queue_cmd(F_ADD, 0, full_box, 0, 1'b0);
    queue_cmd(F_ADD, 7, span_box(C_MAX, C_MAX), 0, 1'b0);
    queue_cmd(F_ADD, 3, span_box(C_MIN, C_MIN), 0, 1'b0);
    queue_cmd(F_QPAIR, 0, '0, 0, 1'b0);
    queue_cmd(F_UPDATE, 5, span_box(-C_ONE, C_ONE), 0, 1'b0);
    queue_cmd(F_REMOVE, 6, '0, 0, 1'b0);
    queue_cmd(F_ADD, 1, span_box(C_ONE, -C_ONE), 0, 1'b0);
    queue_cmd(F_QBOX, 2, full_box, 0, 1'b0);
    queue_cmd(F_UPDATE, 7, span_box(C_MIN, C_MIN), 0, 1'b0);
    queue_cmd(FUNC_SPARE, 4, full_box, 0, 1'b0);
    queue_cmd(F_REMOVE, 0, '0, 0, 1'b0);
    queue_cmd(F_QPAIR, 0, '0, 0, 1'b0);
    for (int s = 0; s < TABLE_DEPTH; s++) queue_cmd(F_ADD, s, full_box, 30, 1'b0);
    queue_cmd(F_QPAIR, 0, '0, 0, 1'b0);
    queue_cmd(F_QBOX, 0, span_box(C_MAX, C_MIN), 0, 1'b0);
    queue_cmd(F_CLEAR, 0, '0, 0, 1'b0);

    // Random part in three pacing phases, each opened by a full drain.
    for (int n = 0; n < 325; n++) begin
      gap = (n < 110) ? 0 : (n < 220) ? 63 : 14;
      r = $urandom_range(0, 99);
      if (r < 28)      f = F_ADD;
      else if (r < 40) f = F_UPDATE;
      else if (r < 52) f = F_REMOVE;
      else if (r < 64) f = F_QPAIR;
      else if (r < 82) f = F_QBOX;
      else if (r < 88) f = F_SIZE;
      else if (r < 91) f = F_CLEAR;
      else if (r < 94) f = FUNC_SPARE;
      else             f = F_ADD;
      queue_cmd(f, $urandom_range(0, 7), rand_box(), gap,
                n == 0 || n == 110 || n == 165 || n == 220);
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_backlog.size() != 0 || start) @(posedge clk_i);
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Covered %0d commands: %0d pair scans (up to %0d hits), %0d box scans.",
             cmds_taken, pair_scans, widest_burst, box_scans);
    $display("Checked %0d result words, %0d mismatches.", replies_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("aabb_table_overlap_query verification clean");
    end else begin
      $display("aabb_table_overlap_query verification failed");
    end
    $finish;
  end

  // Watchdog on the cycle count.
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d result words outstanding.",
             cycle_count, replies_due.size());
    $display("aabb_table_overlap_query verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/aabb_pkg.sv
sv/aabb_box_ram.sv
sv/aabb_ovl_unit.sv
sv/aabb_table_overlap_query.sv
bench/tb_aabb_table_overlap_query.sv
